### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TKBD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("touch key check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TKBD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("touch key check failed");

`endif

### rtl/tkbd_pkg.sv
`default_nettype none
package tkbd_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int GATE_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CALIB_COUNT = 10;
  localparam int IDX_W       = $clog2(CALIB_COUNT + 1);
  localparam int SUM_W       = SAMPLE_W + 4;
  localparam int CNT_W       = 3;
  localparam int LOCK_W      = 2;
  localparam int HI_W        = SAMPLE_W + 4;
  localparam int LO_W        = SAMPLE_W + 1;

  // sum of the middle six / 6 = (sum >> 1) / 3, by reciprocal multiply
  localparam int DIV_X_W     = SAMPLE_W + 2;
  localparam int RECIP_SHIFT = SAMPLE_W + 4;
  localparam int RECIP_W     = SAMPLE_W + 3;
  localparam int PROD_W      = DIV_X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);

  localparam int GROUP_SMALL    = 3;
  localparam int GROUP_REPEAT   = 6;
  localparam int LOCKOUT_RELOAD = 3;
  localparam int GATE_RESET     = 100;

  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE   = 1'd1;

  localparam logic KIND_CALIB = 1'b0;
  localparam logic KIND_SCAN  = 1'b1;

  typedef struct packed {
    logic capture;
    logic cal_upd;
    logic sub_min;
    logic sub_max;
    logic mul;
    logic div_fin;
    logic scan_upd;
    logic eval;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic calibrated;
    logic cal_last;
    logic group_end;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

### rtl/tkbd_ctrl.sv
`default_nettype none
module tkbd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tkbd_pkg::stat_t  stat,
  output tkbd_pkg::cmd_t   cmd
);
  import tkbd_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CAL    = 4'd1;
  localparam logic [3:0] S_SUBMIN = 4'd2;
  localparam logic [3:0] S_SUBMAX = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_EVAL   = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = stat.calibrated ? S_SCAN : S_CAL;
        end
      end
      S_CAL: begin
        cmd.cal_upd = 1'b1;
        state_nxt   = stat.cal_last ? S_SUBMIN : S_IDLE;
      end
      S_SUBMIN: begin
        cmd.sub_min = 1'b1;
        state_nxt   = S_SUBMAX;
      end
      S_SUBMAX: begin
        cmd.sub_max = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_fin = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_SCAN: begin
        cmd.scan_upd = 1'b1;
        state_nxt    = stat.group_end ? S_EVAL : S_IDLE;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/tkbd_dp.sv
`default_nettype none
module tkbd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tkbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tkbd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [tkbd_pkg::SAMPLE_W-1:0]       in_sample,
  input  tkbd_pkg::cmd_t                      cmd,
  output tkbd_pkg::stat_t                     stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_result_kind,
  output logic                                out_pressed,
  output logic [tkbd_pkg::SAMPLE_W-1:0]       out_baseline_value,
  output logic                                out_init_fail
);
  import tkbd_pkg::*;

  logic                  repeat_r;
  logic [GATE_W-1:0]     gate_r;
  logic [SAMPLE_W-1:0]   sample_r;
  logic [SAMPLE_W-1:0]   min1_r, min2_r, max1_r, max2_r;
  logic [SUM_W-1:0]      acc_r;
  logic [PROD_W-1:0]     prod_r;
  logic [SAMPLE_W-1:0]   baseline_r;
  logic [IDX_W-1:0]      calib_index_r;
  logic                  calibrated_r;
  logic [SAMPLE_W-1:0]   group_max_r;
  logic [CNT_W-1:0]      group_count_r;
  logic [LOCK_W-1:0]     lockout_r;
  logic [LOCK_W-1:0]     lockout_nxt;
  logic                  res_kind_r, res_pressed_r, res_fail_r;
  logic                  pressed_nxt;
  logic                  out_valid_r;
  logic                  out_kind_r, out_pressed_r, out_fail_r;
  logic [SAMPLE_W-1:0]   out_base_r;

  logic [SUM_W-1:0]      min_pair, max_pair;
  logic [CNT_W-1:0]      cnt_inc, grp_size;
  logic [SAMPLE_W-1:0]   gm_nxt, quot;
  logic [LO_W-1:0]       lo_bound;
  logic [HI_W-1:0]       hi_bound;
  logic                  grp_valid;
  logic [LOCK_W-1:0]     lk_base;

  assign min_pair = SUM_W'(min1_r) + SUM_W'(min2_r);
  assign max_pair = SUM_W'(max1_r) + SUM_W'(max2_r);
  assign cnt_inc  = group_count_r + CNT_W'(1);
  assign grp_size = repeat_r ? CNT_W'(GROUP_REPEAT) : CNT_W'(GROUP_SMALL);
  assign gm_nxt   = (sample_r > group_max_r) ? sample_r : group_max_r;
  assign quot     = prod_r[RECIP_SHIFT +: SAMPLE_W];
  assign lo_bound = LO_W'(baseline_r) + LO_W'(gate_r);
  assign hi_bound = HI_W'({baseline_r, 3'b000}) + HI_W'({baseline_r, 1'b0});
  assign grp_valid = (HI_W'(group_max_r) > HI_W'(lo_bound)) &&
                     (HI_W'(group_max_r) < hi_bound);
  assign lk_base  = repeat_r ? '0 : lockout_r;

  always_comb begin
    if (grp_valid) begin
      pressed_nxt = (lk_base == '0);
      lockout_nxt = LOCK_W'(LOCKOUT_RELOAD - 1);
    end else begin
      pressed_nxt = 1'b0;
      lockout_nxt = (lk_base != '0) ? lk_base - LOCK_W'(1) : '0;
    end
  end

  assign stat.calibrated = calibrated_r;
  assign stat.cal_last   = (calib_index_r == IDX_W'(CALIB_COUNT - 1));
  assign stat.group_end  = (cnt_inc >= grp_size);
  assign stat.out_busy   = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_r <= 1'b0;
      gate_r   <= GATE_W'(GATE_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPEAT: repeat_r <= cfg_wdata[0];
        CFG_GATE:   gate_r   <= cfg_wdata[GATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
    end
    if (cmd.mul) begin
      prod_r <= acc_r[DIV_X_W:1] * RECIP;
    end
    if (cmd.eval) begin
      res_kind_r    <= KIND_SCAN;
      res_pressed_r <= pressed_nxt;
      res_fail_r    <= 1'b0;
    end else if (cmd.div_fin) begin
      res_kind_r    <= KIND_CALIB;
      res_pressed_r <= 1'b0;
      res_fail_r    <= quot[SAMPLE_W-1];
    end
    if (cmd.emit) begin
      out_kind_r    <= res_kind_r;
      out_pressed_r <= res_pressed_r;
      out_fail_r    <= res_fail_r;
      out_base_r    <= baseline_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min1_r        <= '1;
      min2_r        <= '1;
      max1_r        <= '0;
      max2_r        <= '0;
      acc_r         <= '0;
      baseline_r    <= '0;
      calib_index_r <= '0;
      calibrated_r  <= 1'b0;
      group_max_r   <= '0;
      group_count_r <= '0;
      lockout_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.cal_upd) begin
        if (sample_r < min1_r) begin
          min2_r <= min1_r;
          min1_r <= sample_r;
        end else if (sample_r < min2_r) begin
          min2_r <= sample_r;
        end
        if (sample_r > max1_r) begin
          max2_r <= max1_r;
          max1_r <= sample_r;
        end else if (sample_r > max2_r) begin
          max2_r <= sample_r;
        end
        acc_r         <= acc_r + SUM_W'(sample_r);
        calib_index_r <= calib_index_r + IDX_W'(1);
      end
      if (cmd.sub_min) begin
        acc_r <= acc_r - min_pair;
      end
      if (cmd.sub_max) begin
        acc_r <= acc_r - max_pair;
      end
      if (cmd.div_fin) begin
        baseline_r    <= quot;
        calibrated_r  <= 1'b1;
        calib_index_r <= '0;
      end
      if (cmd.scan_upd) begin
        group_max_r   <= gm_nxt;
        group_count_r <= cnt_inc;
      end
      if (cmd.eval) begin
        lockout_r     <= lockout_nxt;
        group_max_r   <= '0;
        group_count_r <= '0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_pressed        = out_pressed_r;
  assign out_baseline_value = out_base_r;
  assign out_init_fail      = out_fail_r;

endmodule
`default_nettype wire

### rtl/touch_key_baseline_detect.sv
// Capacitive touch key detector on charge-time samples. The first ten
// samples calibrate: the two smallest and two largest are dropped and the
// rest averaged into the baseline, reported in one calibration transaction
// (init_fail set when the baseline is above 32767). Later samples form scan
// groups of 3 (6 with repeat_mode); each group yields one transaction that
// flags a new press when its maximum lies above baseline + gate_threshold
// and below 10 x baseline. The sequencer takes one sample at a time:
// in_ready is low from acceptance until the sample is done. A sample that
// ends a scan group then passes through evaluate and emit states, the tenth
// calibration sample through subtract, subtract, reciprocal multiply, scale
// and emit; emit waits while an earlier result still waits on out_ready.
// Configuration writes take effect on the next cycle.
`default_nettype none
module touch_key_baseline_detect (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tkbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tkbd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tkbd_pkg::SAMPLE_W-1:0]     in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_result_kind,
  output logic                              out_pressed,
  output logic [tkbd_pkg::SAMPLE_W-1:0]     out_baseline_value,
  output logic                              out_init_fail
);
  import tkbd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tkbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tkbd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_sample          (in_sample),
    .cmd                (cmd),
    .stat               (stat),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_result_kind    (out_result_kind),
    .out_pressed        (out_pressed),
    .out_baseline_value (out_baseline_value),
    .out_init_fail      (out_init_fail)
  );

endmodule
`default_nettype wire

### rtl/tkbd_checker.sv
`default_nettype none
`include "assert_macros.svh"
module tkbd_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tkbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tkbd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [tkbd_pkg::SAMPLE_W-1:0]     in_sample,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              out_result_kind,
  input  logic                              out_pressed,
  input  logic [tkbd_pkg::SAMPLE_W-1:0]     out_baseline_value,
  input  logic                              out_init_fail
);
  import tkbd_pkg::*;

  `TKBD_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_baseline_value) && $stable(out_result_kind))
  `TKBD_ASSERT_IMP(a_scan_no_fail, out_valid && (out_result_kind == KIND_SCAN),
    !out_init_fail)
  `TKBD_ASSERT_IMP(a_calib_no_press, out_valid && (out_result_kind == KIND_CALIB),
    !out_pressed)
  `TKBD_ASSERT_IMP(a_calib_fail_msb, out_valid && (out_result_kind == KIND_CALIB),
    out_init_fail == out_baseline_value[SAMPLE_W-1])

endmodule

bind touch_key_baseline_detect tkbd_checker u_tkbd_checker (.*);
`default_nettype wire
